>>> rtl/core/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle rasterizer: field widths,
// operation codes and the octet descriptor passed from front end to back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

	// coordinate range of the center and radius inputs
	localparam int COORD_BITS = 11;
	localparam int IN_W       = 11;	// width of center_x, center_y, radius ports

	// internal state widths
	localparam int OX_W  = 12;
	localparam int OY_W  = 13;
	localparam int DEC_W = 16;
	localparam int PIX_W = 13;
	localparam int COLOR_W = 32;

	// mask applied to center and radius inputs
	localparam logic [IN_W-1:0] CMASK = IN_W'((64'd1 << COORD_BITS) - 64'd1);

	// decision update constants
	localparam logic [DEC_W-1:0] DEC_INIT  = DEC_W'(3);
	localparam logic [DEC_W-1:0] STEP_DIAG = DEC_W'(10);
	localparam logic [DEC_W-1:0] STEP_AXIS = DEC_W'(6);

	localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(255);

	// pixels per octet
	localparam int PIX_PER_OCTET = 8;
	localparam int CNT_W = $clog2(PIX_PER_OCTET);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIX_PER_OCTET - 1);

	// octet queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// one octet of mirrored pixels waiting to be emitted
	typedef struct packed {
		logic        [PIX_W-1:0]   cx;
		logic        [PIX_W-1:0]   cy;
		logic        [PIX_W-1:0]   ox;
		logic        [PIX_W-1:0]   oy;
		logic        [COLOR_W-1:0] color;
		logic                      done;
	} octet_t;

endpackage

`default_nettype wire

>>> rtl/core/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Front end: takes start and step items, runs one midpoint iteration per
// step, holds the color register and queues an octet for every emitting item.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front
	import mcr_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	// item channel
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                op,
	input  wire  [IN_W-1:0]    center_x,
	input  wire  [IN_W-1:0]    center_y,
	input  wire  [IN_W-1:0]    radius,
	// color register write
	input  wire                cfg_we,
	input  wire  [COLOR_W-1:0] cfg_wdata,
	// octet queue push side
	input  wire                q_full,
	output logic               q_push,
	output octet_t             q_data
);

	logic                    [COLOR_W-1:0] color_q;
	logic signed             [OX_W-1:0]    ox_q;
	logic signed             [OY_W-1:0]    oy_q;
	logic signed             [DEC_W-1:0]   dec_q;
	logic                    [IN_W-1:0]    cx_q;
	logic                    [IN_W-1:0]    cy_q;
	logic                                  active_q;

	logic                                  xfer;
	logic                                  is_start;
	logic                                  step_ok;
	logic                                  emit;
	logic                    [IN_W-1:0]    cx_in;
	logic                    [IN_W-1:0]    cy_in;
	logic                    [IN_W-1:0]    r_in;
	logic signed             [OX_W-1:0]    ox_inc;
	logic signed             [OY_W-1:0]    oy_dec;
	logic signed             [OY_W-1:0]    oy_nxt;
	logic signed             [DEC_W-1:0]   dec_nxt;
	logic signed             [DEC_W-1:0]   dec_start;
	logic signed             [DEC_W-1:0]   diff;
	logic                                  dec_pos;
	logic                                  step_done;

	// classify the incoming item
	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;
	assign is_start = (op == OP_START);
	assign step_ok  = active_q && !(oy_q < OY_W'(ox_q));
	assign emit     = is_start || step_ok;
	assign q_push   = xfer && emit;

	assign cx_in = center_x & CMASK;
	assign cy_in = center_y & CMASK;
	assign r_in  = radius & CMASK;

	// one midpoint iteration
	always_comb begin
		ox_inc    = ox_q + OX_W'(1);
		oy_dec    = oy_q - OY_W'(1);
		dec_pos   = !dec_q[DEC_W-1] && (dec_q != '0);
		diff      = DEC_W'(ox_inc) - DEC_W'(oy_dec);
		if (dec_pos) begin
			oy_nxt  = oy_dec;
			dec_nxt = dec_q + (diff <<< 2) + STEP_DIAG;
		end else begin
			oy_nxt  = oy_q;
			dec_nxt = dec_q + (DEC_W'(ox_inc) <<< 2) + STEP_AXIS;
		end
		step_done = oy_nxt < OY_W'(ox_inc);
		dec_start = DEC_INIT - DEC_W'({r_in, 1'b0});
	end

	// octet descriptor for the queue
	always_comb begin
		q_data.color = color_q;
		if (is_start) begin
			q_data.cx   = PIX_W'(cx_in);
			q_data.cy   = PIX_W'(cy_in);
			q_data.ox   = '0;
			q_data.oy   = PIX_W'(r_in);
			q_data.done = 1'b0;
		end else begin
			q_data.cx   = PIX_W'(cx_q);
			q_data.cy   = PIX_W'(cy_q);
			q_data.ox   = PIX_W'(ox_inc);
			q_data.oy   = PIX_W'(oy_nxt);
			q_data.done = step_done;
		end
	end

	// circle state and color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= COLOR_RESET;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (xfer && is_start) begin
				cx_q     <= cx_in;
				cy_q     <= cy_in;
				ox_q     <= '0;
				oy_q     <= OY_W'(r_in);
				dec_q    <= dec_start;
				active_q <= 1'b1;
			end else if (xfer && step_ok) begin
				ox_q  <= ox_inc;
				oy_q  <= oy_nxt;
				dec_q <= dec_nxt;
				if (step_done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// a start always leaves a circle in progress at the first offset
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && is_start) |=> (active_q && ox_q == '0))
		else $error("start did not arm the circle");

	// a finishing octet ends the circle
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_data.done) |=> !active_q)
		else $error("circle still active after done octet");

endmodule

`default_nettype wire

>>> rtl/core/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Short register queue of octet descriptors between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_queue
	import mcr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	input  wire octet_t push_data,
	output logic        full,
	input  wire         pop,
	output octet_t      head,
	output logic        not_empty
);

	octet_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("octet queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("octet queue underflow");

endmodule

`default_nettype wire

>>> rtl/core/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Back end: walks the eight mirrored pixels of the head octet, one pixel
// per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back
	import mcr_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	// octet queue pop side
	input  wire                q_valid,
	input  wire octet_t        q_head,
	output logic               q_pop,
	// pixel channel
	output logic               out_valid,
	input  wire                out_ready,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last,
	output logic               done_res
);

	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [PIX_W-1:0]   px_q;
	logic [PIX_W-1:0]   py_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;
	logic               done_q;

	logic               load;
	logic               cnt_end;
	logic [PIX_W-1:0]   a;
	logic [PIX_W-1:0]   b;
	logic [PIX_W-1:0]   px_nxt;
	logic [PIX_W-1:0]   py_nxt;

	assign load    = q_valid && (!out_valid_q || out_ready);
	assign cnt_end = (cnt_q == CNT_LAST);
	assign q_pop   = load && cnt_end;

	// mirror select: bit 2 swaps axes, bit 1 negates x term, bit 0 negates y term
	always_comb begin
		a      = cnt_q[2] ? q_head.oy : q_head.ox;
		b      = cnt_q[2] ? q_head.ox : q_head.oy;
		px_nxt = cnt_q[1] ? (q_head.cx - a) : (q_head.cx + a);
		py_nxt = cnt_q[0] ? (q_head.cy - b) : (q_head.cy + b);
	end

	// pixel counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q       <= cnt_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q    <= px_nxt;
			py_q    <= py_nxt;
			color_q <= q_head.color;
			last_q  <= cnt_end;
			done_q  <= cnt_end && q_head.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = color_q;
	assign last        = last_q;
	assign done_res    = done_q;

	// the eighth pixel carries the last flag
	a_last_on_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid_q && last_q))
		else $error("eighth pixel lost its last flag");

	// the counter only moves together with a pixel load
	a_cnt_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(cnt_q))
		else $error("pixel counter moved without a load");

endmodule

`default_nettype wire

>>> rtl/core/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle rasterizer: start and step items in, mirrored pixels out.
// ----------------------------------------------------------------------------
//  Input channel (in_valid/in_ready): op 0 starts a circle at center_x,
//  center_y with the given radius; op 1 advances one iteration. Each start,
//  and each step while a circle is in progress, yields eight pixels on the
//  output channel (out_valid/out_ready), the eighth flagged by last, and by
//  done_res when the circle is complete. A step with no circle in progress
//  is accepted and yields nothing. cfg_we/cfg_wdata write the pixel
//  color; the value at item transfer goes with that item's pixels.
//  After the item transfer the octet is written into the queue, then its
//  first pixel is loaded into the output register. The output register
//  sends one pixel per cycle while out_ready is high; the front end runs
//  one iteration per cycle while the queue is not full, and a two-entry
//  octet queue lets it take the next item meanwhile.
//  Reset clears the circle state, empties the queue and sets the color to
//  0x000000FF. When the receiver stalls, the output register holds its pixel,
//  the queue fills, and in_ready drops once two octets are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer_unit
	import mcr_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                op,
	input  wire  [IN_W-1:0]    center_x,
	input  wire  [IN_W-1:0]    center_y,
	input  wire  [IN_W-1:0]    radius,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last,
	output logic               done_res,
	input  wire                cfg_we,
	input  wire  [COLOR_W-1:0] cfg_wdata
);

	logic   q_full;
	logic   q_push;
	octet_t q_data;
	logic   q_pop;
	octet_t q_head;
	logic   q_valid;

	mcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	mcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_valid)
	);

	mcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last),
		.done_res    (done_res)
	);

endmodule

`default_nettype wire
